@@ rtl/gtr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types and constants of the graph traversal block: field widths,
// input codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VW           = 4;   // vertex index width
  localparam int NW           = 5;   // vertex count width

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_WALK = 1'b1;

  localparam logic MODE_BFS = 1'b0;
  localparam logic MODE_DFS = 1'b1;

  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  // source of the vertex that is visited or pushed
  typedef enum logic [1:0] {
    VS_START,
    VS_SCAN,
    VS_STACK
  } vsel_t;

  typedef struct packed {
    logic  row_wr;
    logic  trav_init;
    logic  visit;
    vsel_t vsel;
    logic  fifo_push;
    logic  fifo_pop;
    logic  row_from_pop;
    logic  stack_push;
    logic  stack_pop;
    logic  j_clr;
    logic  j_top;
    logic  j_inc;
    logic  j_dec;
    logic  bad_out;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic fifo_nonempty;
    logic stack_nonempty;
    logic out_free;
    logic emit_ok;
    logic bit_hit;
    logic j_last;
    logic j_zero;
    logic popped_visited;
    logic start_bad;
  } sts_t;

endpackage

@@ rtl/gtr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_ctrl
// Traversal sequencer: accepts input words, runs the breadth-first or depth-first
// walk one adjacency bit per cycle unless a visit waits, and commands the datapath.
// ----------------------------------------------------------------------------
module gtr_ctrl
  import gtr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic func,
  input  logic walk_mode,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BAD,
    S_BSTART,
    S_BPOP,
    S_BSCAN,
    S_DSTART,
    S_DPOP,
    S_DCHK,
    S_DSCAN,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.vsel   = VS_START;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_LOAD) begin
            cmd.row_wr = 1'b1;
          end else if (sts.start_bad) begin
            state_next = S_BAD;
          end else begin
            cmd.trav_init = 1'b1;
            state_next    = (walk_mode == MODE_DFS) ? S_DSTART : S_BSTART;
          end
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.bad_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_BSTART: begin
        if (sts.emit_ok) begin
          cmd.visit     = 1'b1;
          cmd.fifo_push = 1'b1;
          state_next    = S_BPOP;
        end
      end
      S_BPOP: begin
        if (sts.fifo_nonempty) begin
          cmd.fifo_pop = 1'b1;
          cmd.j_clr    = 1'b1;
          state_next   = S_BSCAN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_BSCAN: begin
        cmd.vsel = VS_SCAN;
        if (!sts.bit_hit || sts.emit_ok) begin
          if (sts.bit_hit) begin
            cmd.visit     = 1'b1;
            cmd.fifo_push = 1'b1;
          end
          if (sts.j_last) begin
            state_next = S_BPOP;
          end else begin
            cmd.j_inc = 1'b1;
          end
        end
      end
      S_DSTART: begin
        cmd.stack_push = 1'b1;
        state_next     = S_DPOP;
      end
      S_DPOP: begin
        if (sts.stack_nonempty) begin
          cmd.stack_pop = 1'b1;
          state_next    = S_DCHK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DCHK: begin
        cmd.vsel = VS_STACK;
        if (sts.popped_visited) begin
          state_next = S_DPOP;
        end else if (sts.emit_ok) begin
          cmd.visit        = 1'b1;
          cmd.row_from_pop = 1'b1;
          cmd.j_top        = 1'b1;
          state_next       = S_DSCAN;
        end
      end
      S_DSCAN: begin
        cmd.vsel       = VS_SCAN;
        cmd.stack_push = sts.bit_hit;
        if (sts.j_zero) begin
          state_next = S_DPOP;
        end else begin
          cmd.j_dec = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/gtr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_dpath
// Traversal datapath: adjacency rows, visited marks, FIFO, stack memory,
// scan counter, one-word hold-back for the last flag and output register.
// ----------------------------------------------------------------------------
module gtr_dpath
  import gtr_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [NW-1:0]           n,
  input  logic [VW-1:0]           vertex,
  input  logic [MAX_VERTICES-1:0] row_bits,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VW-1:0]           visited_vertex,
  output logic                    last,
  output logic                    bad_start
);

  localparam int SW = $clog2(STACK_DEPTH);

  logic [MAX_VERTICES-1:0] adj [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] cur_row;
  logic [VW-1:0]           fifo_mem [MAX_VERTICES];
  logic [NW-1:0]           head;
  logic [NW-1:0]           tail;
  logic [VW-1:0]           stk_mem [STACK_DEPTH];
  logic [SW:0]             depth;
  logic [SW:0]             depth_m1;
  logic [VW-1:0]           stk_rdata;
  logic [VW-1:0]           start_v;
  logic [VW-1:0]           j;
  logic [NW-1:0]           n_m1;
  logic [VW-1:0]           sel_v;
  logic                    pend_valid;
  logic [VW-1:0]           pend_v;
  logic                    out_free;
  logic                    stk_room;

  assign depth_m1 = depth - 1'b1;
  assign n_m1     = n - 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign stk_room = (depth < (SW + 1)'(STACK_DEPTH));

  always_comb begin
    case (cmd.vsel)
      VS_START: sel_v = start_v;
      VS_SCAN:  sel_v = j;
      VS_STACK: sel_v = stk_rdata;
      default:  sel_v = start_v;
    endcase
  end

  always_comb begin
    sts.fifo_nonempty  = (head != tail);
    sts.stack_nonempty = (depth != '0);
    sts.out_free       = out_free;
    sts.emit_ok        = !pend_valid || out_free;
    sts.bit_hit        = cur_row[j] && !visited[j];
    sts.j_last         = ({1'b0, j} == n_m1);
    sts.j_zero         = (j == '0);
    sts.popped_visited = visited[stk_rdata];
    sts.start_bad      = ({1'b0, vertex} >= n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
      visited    <= '0;
      head       <= '0;
      tail       <= '0;
      depth      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.bad_out || cmd.flush || (cmd.visit && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.row_wr) begin
        adj[vertex] <= row_bits;
      end
      if (cmd.trav_init) begin
        visited    <= '0;
        head       <= '0;
        tail       <= '0;
        depth      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.visit) begin
        visited[sel_v] <= 1'b1;
        pend_valid     <= 1'b1;
      end
      if (cmd.fifo_push) begin
        tail <= tail + 1'b1;
      end
      if (cmd.fifo_pop) begin
        head <= head + 1'b1;
      end
      if (cmd.stack_push && stk_room) begin
        depth <= depth + 1'b1;
      end
      if (cmd.stack_pop) begin
        depth <= depth_m1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.trav_init) begin
      start_v <= vertex;
    end
    if (cmd.visit) begin
      pend_v <= sel_v;
      if (pend_valid) begin
        visited_vertex <= pend_v;
        last           <= 1'b0;
        bad_start      <= 1'b0;
      end
    end
    if (cmd.bad_out) begin
      visited_vertex <= '0;
      last           <= 1'b1;
      bad_start      <= 1'b1;
    end
    if (cmd.flush) begin
      visited_vertex <= pend_v;
      last           <= 1'b1;
      bad_start      <= 1'b0;
    end
    if (cmd.fifo_pop) begin
      cur_row <= adj[fifo_mem[head[VW-1:0]]];
    end
    if (cmd.row_from_pop) begin
      cur_row <= adj[stk_rdata];
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_top) begin
      j <= n_m1[VW-1:0];
    end else if (cmd.j_inc) begin
      j <= j + 1'b1;
    end else if (cmd.j_dec) begin
      j <= j - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fifo_push) begin
      fifo_mem[tail[VW-1:0]] <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stack_push && stk_room) begin
      stk_mem[depth[SW-1:0]] <= sel_v;
    end
    if (cmd.stack_pop) begin
      stk_rdata <= stk_mem[depth_m1[SW-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= NW'(MAX_VERTICES))
    else $error("fifo tail beyond vertex count");

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("fifo head passed tail");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= (SW + 1)'(STACK_DEPTH))
    else $error("stack depth overflow");

  a_visit_fresh: assert property (@(posedge clk) disable iff (rst)
    cmd.visit |-> !visited[sel_v])
    else $error("vertex visited twice");

  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_start |-> last && (visited_vertex == '0))
    else $error("malformed bad start word");
`endif

endmodule

@@ rtl/graph_traversal_bfs_dfs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_traversal_bfs_dfs
// Adjacency-matrix graph walker with breadth-first and depth-first modes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): func 0 writes row_bits as the adjacency
// row of vertex and leaves in_stall low. func 1 starts a walk at vertex and
// in_stall stays high until the walk's last word sits in the output register.
// Output channel (out_valid/out_stall): one word per visited vertex in visit
// order, last set on the final one. A start vertex not below vertex_count
// gives a single word with bad_start and last set.
// Timing: the sequencer tests one adjacency bit per cycle unless a visit waits
// for the output register. Each word is held back one visit so that last is
// known, and a stalled output register stops the walk at the next visit. Row
// loads are taken while an earlier word waits.
// Registers (APB, offset 0x0 vertex_count, 0x4 walk_mode) must be written only
// while the block is idle; the block does not enforce it. Synchronous reset
// clears all rows to zero, vertex_count to 16 and walk_mode to breadth-first.
// ----------------------------------------------------------------------------
module graph_traversal_bfs_dfs
  import gtr_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [VW-1:0]           vertex,
  input  logic [MAX_VERTICES-1:0] row_bits,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VW-1:0]           visited_vertex,
  output logic                    last,
  output logic                    bad_start,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [NW-1:0] vertex_count;
  logic          walk_mode;
  logic [NW-1:0] n;
  logic          reg_wr;
  cmd_t          cmd;
  sts_t          sts;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= NW'(MAX_VERTICES);
      walk_mode    <= MODE_BFS;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_VCOUNT: vertex_count <= pwdata[NW-1:0];
        REG_MODE:   walk_mode    <= pwdata[0];
        default:    walk_mode    <= walk_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VCOUNT: prdata = {{(32 - NW){1'b0}}, vertex_count};
      REG_MODE:   prdata = {31'b0, walk_mode};
      default:    prdata = '0;
    endcase
  end

  assign n = (vertex_count > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vertex_count;

  gtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .walk_mode (walk_mode),
    .sts       (sts),
    .cmd       (cmd)
  );

  gtr_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .n              (n),
    .vertex         (vertex),
    .row_bits       (row_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .visited_vertex (visited_vertex),
    .last           (last),
    .bad_start      (bad_start)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adjacency-matrix BFS/DFS walker. Rows are loaded
// and walks started on the input channel. A scoreboard class keeps its own
// copy of the matrix and the registers and works out each walk's visit order.
// Every output word is compared with the oldest expected word. A short
// directed set covers full and empty rows, both walk orders, duplicate stack
// entries, bad starts and out-of-range vertex counts. Random phases follow,
// with random handshake gaps, a calm phase and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import gtr_pkg::*;

  typedef struct {
    logic [3:0] vtx;
    logic       fin;
    logic       bad;
  } visit_t;

  class walk_scoreboard;
    logic [15:0] rows [16];
    logic [4:0]  vcount;
    logic        mode;
    visit_t      expected [$];
    int          errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      vcount = 5'd16;
      mode   = MODE_BFS;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_VCOUNT) vcount = val[4:0];
      else mode = val[0];
    endfunction

    function void push_visit(int v, logic bad);
      visit_t w;
      w.vtx = v[3:0];
      w.fin = 1'b0;
      w.bad = bad;
      expected.push_back(w);
    endfunction

    // visit order of one walk, appended to the expected words
    function void predict_walk(int start);
      int  n;
      int  first;
      int  u;
      bit  seen [16];
      int  pend [$];
      n     = (vcount > 16) ? 16 : vcount;
      first = expected.size();
      foreach (seen[i]) seen[i] = 0;
      if (start >= n) begin
        push_visit(0, 1'b1);
      end else if (mode == MODE_BFS) begin
        seen[start] = 1;
        push_visit(start, 1'b0);
        pend.push_back(start);
        while (pend.size() > 0) begin
          u = pend.pop_front();
          for (int j = 0; j < n; j++)
            if (rows[u][j] && !seen[j]) begin
              seen[j] = 1;
              push_visit(j, 1'b0);
              pend.push_back(j);
            end
        end
      end else begin
        pend.push_back(start);
        while (pend.size() > 0) begin
          u = pend.pop_back();
          if (seen[u]) continue;
          seen[u] = 1;
          push_visit(u, 1'b0);
          for (int j = n - 1; j >= 0; j--)
            if (rows[u][j] && !seen[j]) pend.push_back(j);
        end
      end
      if (expected.size() > first) expected[expected.size() - 1].fin = 1'b1;
    endfunction

    function void note_word(logic f, logic [3:0] v, logic [15:0] r);
      if (f == FUNC_LOAD) rows[v] = r;
      else predict_walk(v);
    endfunction

    function void check_visit(logic [3:0] v, logic l, logic b);
      visit_t want;
      if (expected.size() == 0) begin
        $error("unexpected word: visited_vertex %0d last %0d bad_start %0d", v, l, b);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (v !== want.vtx) begin
        $error("visited_vertex: expected %0d, got %0d", want.vtx, v);
        errors++;
      end
      if (l !== want.fin) begin
        $error("last: expected %0d, got %0d", want.fin, l);
        errors++;
      end
      if (b !== want.bad) begin
        $error("bad_start: expected %0d, got %0d", want.bad, b);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    func;
  logic [VW-1:0]           vertex;
  logic [MAX_VERTICES-1:0] row_bits;
  logic                    out_valid;
  logic                    out_stall;
  logic [VW-1:0]           visited_vertex;
  logic                    last;
  logic                    bad_start;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  walk_scoreboard sb;
  int  words_sent = 0;
  bit  calm = 0;
  bit  hold_req = 0;

  graph_traversal_bfs_dfs dut (.*);

  always #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // output side: random stalls, calm stretch, one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_visit(visited_vertex, last, bad_start);

  task automatic send_word(logic f, logic [3:0] v, logic [15:0] r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    vertex   <= v;
    row_bits <= r;
    do @(posedge clk); while (in_stall);
    sb.note_word(f, v, r);
    words_sent++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait until every expected word is out, plus slack for trailing row loads
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_row();
    logic [15:0] r;
    case ($urandom_range(3))
      0: r = 16'($urandom & $urandom & $urandom);
      1: r = 16'($urandom);
      2: r = 16'($urandom | $urandom);
      default: r = 16'(1) << $urandom_range(15);
    endcase
    return r;
  endfunction

  initial begin
    int phase;
    int pick;
    int n_cfg;
    int n_eff;
    rst      = 1'b1;
    in_valid = 1'b0;
    func     = FUNC_LOAD;
    vertex   = '0;
    row_bits = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    sb       = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset config: 16 vertices, breadth-first
    send_word(FUNC_WALK, 4'd3, 16'hFFFF);
    send_word(FUNC_LOAD, 4'd0, 16'hFFFF);
    send_word(FUNC_LOAD, 4'd15, 16'h8001);
    send_word(FUNC_LOAD, 4'd7, 16'h00A0);
    send_word(FUNC_WALK, 4'd0, 16'h0000);
    send_word(FUNC_WALK, 4'd15, 16'h0000);
    settle();

    // four vertices, depth-first; rows reach past the count
    write_reg(REG_VCOUNT, 32'd4);
    write_reg(REG_MODE, 32'(MODE_DFS));
    send_word(FUNC_WALK, 4'd0, 16'h0000);
    send_word(FUNC_WALK, 4'd5, 16'h0000);
    send_word(FUNC_WALK, 4'd15, 16'hFFFF);
    send_word(FUNC_LOAD, 4'd1, 16'h0005);
    send_word(FUNC_WALK, 4'd1, 16'h0000);
    send_word(FUNC_LOAD, 4'd3, 16'h0000);
    send_word(FUNC_WALK, 4'd2, 16'h0000);
    settle();

    // zero vertices: every start is bad
    write_reg(REG_VCOUNT, 32'd0);
    send_word(FUNC_WALK, 4'd0, 16'h0000);
    settle();

    // count above the maximum acts as 16
    write_reg(REG_VCOUNT, 32'd31);
    write_reg(REG_MODE, 32'(MODE_BFS));
    send_word(FUNC_WALK, 4'd15, 16'h0000);
    settle();

    // one vertex: self edge only
    write_reg(REG_VCOUNT, 32'd1);
    send_word(FUNC_WALK, 4'd0, 16'h0000);
    send_word(FUNC_WALK, 4'd1, 16'h0000);

    phase = 0;
    while (words_sent < 410) begin
      pick = $urandom_range(99);
      if (phase == 3) n_cfg = 16;
      else if (pick < 65) n_cfg = $urandom_range(8, 1);
      else if (pick < 90) n_cfg = $urandom_range(16, 9);
      else if (pick < 95) n_cfg = 0;
      else n_cfg = $urandom_range(31, 17);
      n_eff = (n_cfg > 16) ? 16 : n_cfg;
      settle();
      write_reg(REG_VCOUNT, 32'(n_cfg));
      write_reg(REG_MODE, (phase == 3) ? 32'(MODE_DFS) : 32'($urandom_range(1)));
      calm = (phase == 6);
      for (int i = 0; i < 16; i++)
        if (i < n_eff || $urandom_range(9) == 0) send_word(FUNC_LOAD, 4'(i), pick_row());
      if (phase == 3) hold_req = 1;
      repeat ($urandom_range(8, 3)) begin
        if ($urandom_range(9) == 0) send_word(FUNC_LOAD, 4'($urandom_range(15)), pick_row());
        if (n_eff > 0 && $urandom_range(9) != 0)
          send_word(FUNC_WALK, 4'($urandom_range(n_eff - 1)), 16'($urandom));
        else
          send_word(FUNC_WALK, 4'($urandom_range(15)), 16'($urandom));
      end
      phase++;
    end
    settle();

    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
